>>> rtl/jsu_pkg.sv
package jsu_pkg;

  // Default number of entries in the queue between the front and back parts
  localparam int DEF_QUEUE_DEPTH = 2;

  // Error codes carried on error_code
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_EXP_QUOTE    = 3'd1;
  localparam logic [2:0] ERR_CONTROL      = 3'd2;
  localparam logic [2:0] ERR_UNTERM_ESC   = 3'd3;
  localparam logic [2:0] ERR_BAD_UNICODE  = 3'd4;
  localparam logic [2:0] ERR_BAD_ESC      = 3'd5;
  localparam logic [2:0] ERR_UNTERMINATED = 3'd6;

  // Middle part of a burst: nothing, one raw byte, or one code point to encode
  localparam logic [1:0] MID_NONE = 2'd0;
  localparam logic [1:0] MID_RAW  = 2'd1;
  localparam logic [1:0] MID_CP   = 2'd2;

  // Closing part of a burst
  localparam logic [1:0] TAIL_NONE = 2'd0;
  localparam logic [1:0] TAIL_DONE = 2'd1;
  localparam logic [1:0] TAIL_ERR  = 2'd2;

  // Most result items that one input byte can cause
  localparam int MAX_ITEMS = 6;

  // One classified input: optional flushed high surrogate, a middle part, a tail
  typedef struct packed {
    logic        hi_en;
    logic [9:0]  hi;
    logic [1:0]  mid;
    logic [20:0] cp;
    logic [1:0]  tail;
    logic [2:0]  err;
  } desc_t;

  // One result item without its last mark
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic [2:0] error_code;
  } item_t;

endpackage

>>> rtl/jsu_in_if.sv
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

>>> rtl/jsu_out_if.sv
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       string_done;
  logic [2:0] error_code;
  logic       last;

  modport source (output valid, output out_byte, output byte_valid, output string_done,
                  output error_code, output last, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input string_done,
                input error_code, input last, output ready);
endinterface

>>> rtl/jsu_front.sv
module jsu_front (
  input  logic           clk,
  input  logic           rst,
  jsu_in_if.sink         text,
  input  logic           q_full,
  output logic           push,
  output jsu_pkg::desc_t desc
);

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_BODY      = 3'd1;
  localparam logic [2:0] PH_ESC       = 3'd2;
  localparam logic [2:0] PH_HEX1      = 3'd3;
  localparam logic [2:0] PH_HIGH_WAIT = 3'd4;
  localparam logic [2:0] PH_HIGH_ESC  = 3'd5;
  localparam logic [2:0] PH_HEX2      = 3'd6;

  logic [2:0]  phase, phase_next;
  logic [15:0] hex_accum, hex_accum_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [9:0]  pending_high, pending_high_next;

  logic [7:0]  b;
  logic        eoi;
  logic        accept;

  // Hex digit decode
  logic        is_hex;
  logic [3:0]  hex_d;
  logic [15:0] acc_new;
  logic        is_high_sur;
  logic        is_low_sur;

  // Outcome of a byte in the string body
  logic [2:0]  bo_phase;
  logic [1:0]  bo_mid;
  logic [1:0]  bo_tail;
  logic [2:0]  bo_err;

  // Outcome of a byte after a backslash
  logic        es_ok;
  logic        es_u;
  logic [7:0]  es_val;

  jsu_pkg::desc_t d;

  assign b          = text.in_byte;
  assign eoi        = text.end_of_input;
  assign text.ready = !q_full;
  assign accept     = text.valid && text.ready;

  always_comb begin
    is_hex = 1'b1;
    hex_d  = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      hex_d = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      hex_d = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      hex_d = 4'(b - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
    if (eoi) begin
      is_hex = 1'b0;
    end
  end

  assign acc_new     = {hex_accum[11:0], hex_d};
  assign is_high_sur = (acc_new[15:10] == 6'b110110);
  assign is_low_sur  = (acc_new[15:10] == 6'b110111);

  // Classify a body byte: quote ends, control fails, backslash escapes
  always_comb begin
    bo_phase = PH_BODY;
    bo_mid   = jsu_pkg::MID_NONE;
    bo_tail  = jsu_pkg::TAIL_NONE;
    bo_err   = jsu_pkg::ERR_NONE;
    if (b == 8'h22) begin
      bo_phase = PH_IDLE;
      bo_tail  = jsu_pkg::TAIL_DONE;
    end else if (b < 8'h20) begin
      bo_phase = PH_IDLE;
      bo_tail  = jsu_pkg::TAIL_ERR;
      bo_err   = jsu_pkg::ERR_CONTROL;
    end else if (b == 8'h5C) begin
      bo_phase = PH_ESC;
    end else begin
      bo_mid = jsu_pkg::MID_RAW;
    end
  end

  // Classify an escape letter
  always_comb begin
    es_ok  = 1'b1;
    es_u   = 1'b0;
    es_val = b;
    case (b)
      8'h22, 8'h5C, 8'h2F: es_val = b;
      8'h62:               es_val = 8'h08;
      8'h66:               es_val = 8'h0C;
      8'h6E:               es_val = 8'h0A;
      8'h72:               es_val = 8'h0D;
      8'h74:               es_val = 8'h09;
      8'h75: begin
        es_ok = 1'b0;
        es_u  = 1'b1;
      end
      default:             es_ok = 1'b0;
    endcase
  end

  // Next state and burst descriptor
  always_comb begin
    phase_next        = phase;
    hex_accum_next    = hex_accum;
    hex_count_next    = hex_count;
    pending_high_next = pending_high;
    d                 = '0;
    case (phase)
      PH_IDLE: begin
        if (eoi) begin
          d.tail = jsu_pkg::TAIL_ERR;
          d.err  = jsu_pkg::ERR_EXP_QUOTE;
        end else if (b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A) begin
          phase_next = PH_IDLE;
        end else if (b == 8'h22) begin
          phase_next = PH_BODY;
        end else begin
          d.tail = jsu_pkg::TAIL_ERR;
          d.err  = jsu_pkg::ERR_EXP_QUOTE;
        end
      end
      PH_BODY: begin
        if (eoi) begin
          phase_next = PH_IDLE;
          d.tail     = jsu_pkg::TAIL_ERR;
          d.err      = jsu_pkg::ERR_UNTERMINATED;
        end else begin
          phase_next = bo_phase;
          d.mid      = bo_mid;
          d.cp       = 21'(b);
          d.tail     = bo_tail;
          d.err      = bo_err;
        end
      end
      PH_ESC, PH_HIGH_ESC: begin
        d.hi_en = (phase == PH_HIGH_ESC) && !(!eoi && es_u);
        d.hi    = pending_high;
        if (eoi) begin
          phase_next = PH_IDLE;
          d.tail     = jsu_pkg::TAIL_ERR;
          d.err      = jsu_pkg::ERR_UNTERM_ESC;
        end else if (es_u) begin
          phase_next     = (phase == PH_HIGH_ESC) ? PH_HEX2 : PH_HEX1;
          hex_accum_next = '0;
          hex_count_next = '0;
        end else if (es_ok) begin
          phase_next = PH_BODY;
          d.mid      = jsu_pkg::MID_RAW;
          d.cp       = 21'(es_val);
        end else begin
          phase_next = PH_IDLE;
          d.tail     = jsu_pkg::TAIL_ERR;
          d.err      = jsu_pkg::ERR_BAD_ESC;
        end
      end
      PH_HEX1, PH_HEX2: begin
        d.hi = pending_high;
        if (!is_hex) begin
          phase_next = PH_IDLE;
          d.hi_en    = (phase == PH_HEX2);
          d.tail     = jsu_pkg::TAIL_ERR;
          d.err      = jsu_pkg::ERR_BAD_UNICODE;
        end else begin
          hex_accum_next = acc_new;
          hex_count_next = hex_count + 2'd1;
          if (hex_count == 2'd3) begin
            if (phase == PH_HEX2 && is_low_sur) begin
              // Join the surrogate pair into one code point
              phase_next = PH_BODY;
              d.mid      = jsu_pkg::MID_CP;
              d.cp       = 21'h10000 + {1'b0, pending_high, acc_new[9:0]};
            end else begin
              d.hi_en = (phase == PH_HEX2);
              if (is_high_sur) begin
                phase_next        = PH_HIGH_WAIT;
                pending_high_next = acc_new[9:0];
              end else begin
                phase_next = PH_BODY;
                d.mid      = jsu_pkg::MID_CP;
                d.cp       = 21'(acc_new);
              end
            end
          end
        end
      end
      PH_HIGH_WAIT: begin
        d.hi = pending_high;
        if (eoi) begin
          phase_next = PH_IDLE;
          d.hi_en    = 1'b1;
          d.tail     = jsu_pkg::TAIL_ERR;
          d.err      = jsu_pkg::ERR_UNTERMINATED;
        end else if (b == 8'h5C) begin
          phase_next = PH_HIGH_ESC;
        end else begin
          phase_next = bo_phase;
          d.hi_en    = 1'b1;
          d.mid      = bo_mid;
          d.cp       = 21'(b);
          d.tail     = bo_tail;
          d.err      = bo_err;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  assign push = accept && (d.hi_en || d.mid != jsu_pkg::MID_NONE ||
                           d.tail != jsu_pkg::TAIL_NONE);
  assign desc = d;

  // Advance the parser state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      hex_accum    <= '0;
      hex_count    <= '0;
      pending_high <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      hex_accum    <= hex_accum_next;
      hex_count    <= hex_count_next;
      pending_high <= pending_high_next;
    end
  end

endmodule

>>> rtl/jsu_queue.sv
module jsu_queue #(
  parameter int DEPTH = jsu_pkg::DEF_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  jsu_pkg::desc_t din,
  output logic           full,
  output logic           valid,
  output jsu_pkg::desc_t dout,
  input  logic           pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jsu_pkg::desc_t entries [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign dout  = entries[rd_ptr];

  // Store pushed descriptors
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/jsu_back.sv
module jsu_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  jsu_pkg::desc_t desc,
  output logic           pop,
  jsu_out_if.source      result
);

  localparam int IW = $clog2(jsu_pkg::MAX_ITEMS);

  jsu_pkg::item_t items [jsu_pkg::MAX_ITEMS];
  logic [IW-1:0]  count;
  logic [IW-1:0]  idx;
  logic           busy;

  jsu_pkg::item_t built [jsu_pkg::MAX_ITEMS];
  logic [IW-1:0]  built_count;

  logic           adv;
  logic           final_item;
  logic           load;

  // UTF-8 encoding of the middle code point
  logic [7:0]     enc [4];
  logic [2:0]     enc_len;
  logic [15:0]    hi_cp;

  always_comb begin
    enc[0]  = 8'h00;
    enc[1]  = 8'h00;
    enc[2]  = 8'h00;
    enc[3]  = 8'h00;
    enc_len = 3'd1;
    if (desc.cp <= 21'h7F) begin
      enc[0]  = desc.cp[7:0];
    end else if (desc.cp <= 21'h7FF) begin
      enc_len = 3'd2;
      enc[0]  = {3'b110, desc.cp[10:6]};
      enc[1]  = {2'b10, desc.cp[5:0]};
    end else if (desc.cp <= 21'hFFFF) begin
      enc_len = 3'd3;
      enc[0]  = {4'b1110, desc.cp[15:12]};
      enc[1]  = {2'b10, desc.cp[11:6]};
      enc[2]  = {2'b10, desc.cp[5:0]};
    end else begin
      enc_len = 3'd4;
      enc[0]  = {5'b11110, desc.cp[20:18]};
      enc[1]  = {2'b10, desc.cp[17:12]};
      enc[2]  = {2'b10, desc.cp[11:6]};
      enc[3]  = {2'b10, desc.cp[5:0]};
    end
  end

  assign hi_cp = {6'b110110, desc.hi};

  // Lay the burst out as a list of items
  always_comb begin
    jsu_pkg::item_t tmp [8];
    logic [2:0]     pos;
    for (int i = 0; i < 8; i++) begin
      tmp[i] = '0;
    end
    pos = 3'd0;
    if (desc.hi_en) begin
      tmp[0].out_byte   = {4'b1110, hi_cp[15:12]};
      tmp[0].byte_valid = 1'b1;
      tmp[1].out_byte   = {2'b10, hi_cp[11:6]};
      tmp[1].byte_valid = 1'b1;
      tmp[2].out_byte   = {2'b10, hi_cp[5:0]};
      tmp[2].byte_valid = 1'b1;
      pos               = 3'd3;
    end
    if (desc.mid == jsu_pkg::MID_RAW) begin
      tmp[pos].out_byte   = desc.cp[7:0];
      tmp[pos].byte_valid = 1'b1;
      pos                 = pos + 3'd1;
    end else if (desc.mid == jsu_pkg::MID_CP) begin
      for (int j = 0; j < 4; j++) begin
        if (3'(j) < enc_len) begin
          tmp[pos].out_byte   = enc[j];
          tmp[pos].byte_valid = 1'b1;
          pos                 = pos + 3'd1;
        end
      end
    end
    if (desc.tail == jsu_pkg::TAIL_DONE) begin
      tmp[pos].string_done = 1'b1;
      pos                  = pos + 3'd1;
    end else if (desc.tail == jsu_pkg::TAIL_ERR) begin
      tmp[pos].error_code = desc.err;
      pos                 = pos + 3'd1;
    end
    for (int i = 0; i < jsu_pkg::MAX_ITEMS; i++) begin
      built[i] = tmp[i];
    end
    built_count = IW'(pos);
  end

  assign adv        = busy && (!result.valid || result.ready);
  assign final_item = (idx == count - 1'b1);
  assign load       = q_valid && (!busy || (adv && final_item));
  assign pop        = load;

  // Hold the current burst and step through it
  always_ff @(posedge clk) begin
    if (load) begin
      items <= built;
      count <= built_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (adv) begin
      if (final_item) begin
        busy <= 1'b0;
      end
      idx <= idx + 1'b1;
    end
  end

  // Output register: take an item whenever the slot frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.out_byte    <= items[idx].out_byte;
      result.byte_valid  <= items[idx].byte_valid;
      result.string_done <= items[idx].string_done;
      result.error_code  <= items[idx].error_code;
      result.last        <= final_item;
    end
  end

endmodule

>>> rtl/json_string_unescape_utf8.sv
// Path: the descriptor of a byte is written into the queue, then loaded into the burst
//   register, and its first result item then goes into the output register.
// Throughput: one input byte per cycle unless the queue is full; the back end sends one
//   result item per cycle unless stalled; a byte of n items (n up to 6) holds it until all are sent.
// Reset: synchronous rst empties the queue and output and returns the parser to idle.
module json_string_unescape_utf8 #(
  parameter int QUEUE_DEPTH = jsu_pkg::DEF_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  jsu_in_if.sink    text,
  jsu_out_if.source result
);

  logic           push;
  logic           q_full;
  logic           q_valid;
  logic           pop;
  jsu_pkg::desc_t front_desc;
  jsu_pkg::desc_t back_desc;

  jsu_front u_front (
    .clk    (clk),
    .rst    (rst),
    .text   (text),
    .q_full (q_full),
    .push   (push),
    .desc   (front_desc)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_desc),
    .full  (q_full),
    .valid (q_valid),
    .dout  (back_desc),
    .pop   (pop)
  );

  jsu_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .desc    (back_desc),
    .pop     (pop),
    .result  (result)
  );

`ifndef ASSERT_OFF
  // A done or error item always closes its burst
  assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.string_done || result.error_code != jsu_pkg::ERR_NONE)
      |-> result.last)
    else $error("done or error item not marked last");

  // Each item is exactly one of byte, done or error
  assert property (@(posedge clk) disable iff (rst)
    result.valid |-> $onehot({result.byte_valid, result.string_done,
                              result.error_code != jsu_pkg::ERR_NONE}))
    else $error("result item kind is not unique");

  // The front never pushes into a full queue
  assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("push into full queue");

  // Error codes stay within the defined set
  assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.error_code <= jsu_pkg::ERR_UNTERMINATED)
    else $error("undefined error code");
`endif

endmodule
